[rtl/core/dkth_pkg.sv]
package dkth_pkg;

    // Ring depths and the index widths that follow from them.
    localparam int DAILY_DEPTH   = 64;
    localparam int MONTHLY_DEPTH = 32;
    localparam int D_IDX_W       = $clog2(DAILY_DEPTH);
    localparam int M_IDX_W       = $clog2(MONTHLY_DEPTH);
    localparam int IDX_W         = (D_IDX_W > M_IDX_W) ? D_IDX_W : M_IDX_W;

    localparam logic [IDX_W-1:0] D_LAST = IDX_W'(DAILY_DEPTH - 1);
    localparam logic [IDX_W-1:0] M_LAST = IDX_W'(MONTHLY_DEPTH - 1);

    // Field widths.
    localparam int KEY_W   = 24;
    localparam int CNT_W   = 64;
    localparam int YEAR_W  = 8;
    localparam int DSLOT_W = 6;
    localparam int MSLOT_W = 5;

    // Years since 1900 of the first year that is recorded after reset (2012).
    localparam logic [YEAR_W-1:0] MIN_YEAR_RESET = 8'd112;

    // Input item layout: day_key, rx_bytes, tx_bytes.
    localparam int IN_W       = 152;
    localparam int IN_KEY_OFF = 0;
    localparam int IN_RX_OFF  = IN_KEY_OFF + KEY_W;
    localparam int IN_TX_OFF  = IN_RX_OFF + CNT_W;

    // Result item layout (accepted travels on tuser).
    localparam int OUT_W       = 272;
    localparam int D_SLOT_OFF  = 0;
    localparam int D_OPEN_OFF  = D_SLOT_OFF + DSLOT_W;
    localparam int D_RX_OFF    = D_OPEN_OFF + 1;
    localparam int D_TX_OFF    = D_RX_OFF + CNT_W;
    localparam int M_SLOT_OFF  = D_TX_OFF + CNT_W;
    localparam int M_OPEN_OFF  = M_SLOT_OFF + MSLOT_W;
    localparam int M_RX_OFF    = M_OPEN_OFF + 1;
    localparam int M_TX_OFF    = M_RX_OFF + CNT_W;
    localparam int OUT_USED_W  = M_TX_OFF + CNT_W;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_TAIL,
        S_TCMP,
        S_SCAN,
        S_SRD,
        S_ADD_RX,
        S_ADD_TX,
        S_OUT
    } t_state;

endpackage

[rtl/core/dkth_ram.sv]
module dkth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/date_keyed_traffic_history.sv]
// Date-keyed traffic history. Each input item carries a date key (year since
// 1900, month, day) with the receive and transmit byte counts of one interval;
// the block adds them into a daily ring of 64 buckets and a monthly ring of 32
// buckets and returns one result item per input item with the slots used and
// the new totals. Items whose year is below min_year change nothing and return
// a result with tuser low and all data zero. One item is worked at a time, and
// the next item is taken only after the result has been taken. The key search
// reads one bucket key per cycle from the key memory of the daily ring and then
// of the monthly ring: the tail bucket first, then from the highest index down,
// stopping at a hit; a rejected item skips the search. All keys go through a
// single shared comparator and all sums through a single 64-bit adder.
// min_year may be written at any time the block is idle; there is no clearing
// pass after reset.
module date_keyed_traffic_history
    import dkth_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration: min_year.
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [YEAR_W-1:0] i_cfg_data,
    // Input items.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // day_key [23:0], rx_bytes [87:24], tx_bytes [151:88]
    input  logic [IN_W-1:0]   s_axis_tdata,
    // Result items.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // daily_slot, daily_opened, daily_rx_total, daily_tx_total, monthly_slot,
    // monthly_opened, monthly_rx_total, monthly_tx_total, zero padding
    output logic [OUT_W-1:0]  m_axis_tdata,
    // accepted
    output logic [0:0]        m_axis_tuser
);

    // Control state.
    t_state               r_state, n_state;
    logic [YEAR_W-1:0]    r_min_year, n_min_year;
    logic                 r_ring, n_ring;
    logic [D_IDX_W-1:0]   r_d_tail, n_d_tail;
    logic [M_IDX_W-1:0]   r_m_tail, n_m_tail;
    logic [DAILY_DEPTH-1:0]   r_d_valid, n_d_valid;
    logic [MONTHLY_DEPTH-1:0] r_m_valid, n_m_valid;

    // Working and result registers.
    logic [KEY_W-1:0]     r_key, n_key;
    logic [CNT_W-1:0]     r_rx, n_rx;
    logic [CNT_W-1:0]     r_tx, n_tx;
    logic [IDX_W-1:0]     r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]     r_slot, n_slot;
    logic                 r_open, n_open;
    logic [CNT_W-1:0]     r_rx_tot, n_rx_tot;
    logic                 r_acc, n_acc;
    logic [DSLOT_W-1:0]   r_d_slot, n_d_slot;
    logic                 r_d_open, n_d_open;
    logic [CNT_W-1:0]     r_d_rx, n_d_rx;
    logic [CNT_W-1:0]     r_d_tx, n_d_tx;
    logic [MSLOT_W-1:0]   r_m_slot, n_m_slot;
    logic                 r_m_open, n_m_open;
    logic [CNT_W-1:0]     r_m_rx, n_m_rx;
    logic [CNT_W-1:0]     r_m_tx, n_m_tx;

    // Memory ports.
    logic [KEY_W-1:0]     d_key_rdata, m_key_rdata;
    logic [2*CNT_W-1:0]   d_sum_rdata, m_sum_rdata;
    logic                 d_key_we, m_key_we, d_sum_we, m_sum_we;
    logic [2*CNT_W-1:0]   sum_wdata;

    // Shared datapath.
    logic [IDX_W-1:0]     tail_cur, tail_nxt, ring_last, key_raddr;
    logic [KEY_W-1:0]     cur_key, rd_key;
    logic                 rd_valid, key_hit;
    logic [2*CNT_W-1:0]   sum_rdata;
    logic [CNT_W-1:0]     add_a, add_b, add_sum;
    logic                 in_fire;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;

    // Tail of the ring in work and its successor with wrap.
    assign tail_cur  = r_ring ? IDX_W'(r_m_tail) : IDX_W'(r_d_tail);
    assign ring_last = r_ring ? M_LAST : D_LAST;
    assign tail_nxt  = (tail_cur == ring_last) ? '0 : tail_cur + 1'b1;

    // Monthly key has the day byte cleared.
    assign cur_key = r_ring ? {r_key[KEY_W-1:8], 8'h00} : r_key;

    // Shared key comparator; an entry never written reads as key zero.
    assign rd_valid = r_ring ? r_m_valid[r_rd_idx[M_IDX_W-1:0]]
                             : r_d_valid[r_rd_idx[D_IDX_W-1:0]];
    assign rd_key   = r_ring ? m_key_rdata : d_key_rdata;
    assign key_hit  = ((rd_valid ? rd_key : '0) == cur_key);

    // Shared 64-bit adder, receive sum first, then transmit sum.
    assign sum_rdata = r_ring ? m_sum_rdata : d_sum_rdata;
    always_comb begin
        if (r_state == S_ADD_RX) begin
            add_a = r_open ? '0 : sum_rdata[CNT_W-1:0];
            add_b = r_rx;
        end else begin
            add_a = r_open ? '0 : sum_rdata[2*CNT_W-1:CNT_W];
            add_b = r_tx;
        end
    end
    assign add_sum   = add_a + add_b;
    assign sum_wdata = {add_sum, r_rx_tot};

    // Key read address: tail first, then a downward scan from the top.
    always_comb begin
        case (r_state)
            S_TAIL:  key_raddr = tail_cur;
            S_TCMP:  key_raddr = ring_last;
            S_SCAN:  key_raddr = (r_rd_idx == '0) ? '0 : r_rd_idx - 1'b1;
            default: key_raddr = r_rd_idx;
        endcase
    end

    // Memory write strobes, all in the last add step.
    assign d_sum_we = (r_state == S_ADD_TX) && !r_ring;
    assign m_sum_we = (r_state == S_ADD_TX) && r_ring;
    assign d_key_we = d_sum_we && r_open;
    assign m_key_we = m_sum_we && r_open;

    // Sequencer: next state and next register values.
    always_comb begin
        n_state    = r_state;
        n_min_year = r_min_year;
        n_ring     = r_ring;
        n_d_tail   = r_d_tail;
        n_m_tail   = r_m_tail;
        n_d_valid  = r_d_valid;
        n_m_valid  = r_m_valid;
        n_key      = r_key;
        n_rx       = r_rx;
        n_tx       = r_tx;
        n_rd_idx   = key_raddr;
        n_slot     = r_slot;
        n_open     = r_open;
        n_rx_tot   = r_rx_tot;
        n_acc      = r_acc;
        n_d_slot   = r_d_slot;
        n_d_open   = r_d_open;
        n_d_rx     = r_d_rx;
        n_d_tx     = r_d_tx;
        n_m_slot   = r_m_slot;
        n_m_open   = r_m_open;
        n_m_rx     = r_m_rx;
        n_m_tx     = r_m_tx;

        if (i_cfg_valid && o_cfg_ready) begin
            n_min_year = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_key  = s_axis_tdata[IN_KEY_OFF +: KEY_W];
                    n_rx   = s_axis_tdata[IN_RX_OFF +: CNT_W];
                    n_tx   = s_axis_tdata[IN_TX_OFF +: CNT_W];
                    n_ring = 1'b0;
                    if (s_axis_tdata[IN_KEY_OFF+16 +: YEAR_W] < r_min_year) begin
                        // Rejected sample: an all-zero result.
                        n_acc    = 1'b0;
                        n_d_slot = '0;
                        n_d_open = 1'b0;
                        n_d_rx   = '0;
                        n_d_tx   = '0;
                        n_m_slot = '0;
                        n_m_open = 1'b0;
                        n_m_rx   = '0;
                        n_m_tx   = '0;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                n_state = S_TCMP;
            end
            S_TCMP: begin
                if (key_hit) begin
                    n_slot  = r_rd_idx;
                    n_open  = 1'b0;
                    n_state = S_SRD;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (key_hit) begin
                    n_slot  = r_rd_idx;
                    n_open  = 1'b0;
                    n_state = S_SRD;
                end else if (r_rd_idx == '0) begin
                    // No bucket holds the key: open the one after the tail.
                    n_slot  = tail_nxt;
                    n_open  = 1'b1;
                    n_state = S_SRD;
                    if (r_ring) begin
                        n_m_tail = tail_nxt[M_IDX_W-1:0];
                    end else begin
                        n_d_tail = tail_nxt[D_IDX_W-1:0];
                    end
                end
            end
            S_SRD: begin
                n_state = S_ADD_RX;
            end
            S_ADD_RX: begin
                n_rx_tot = add_sum;
                n_state  = S_ADD_TX;
            end
            S_ADD_TX: begin
                if (r_ring) begin
                    if (r_open) begin
                        n_m_valid[r_slot[M_IDX_W-1:0]] = 1'b1;
                    end
                    n_m_slot = MSLOT_W'(r_slot);
                    n_m_open = r_open;
                    n_m_rx   = r_rx_tot;
                    n_m_tx   = add_sum;
                    n_acc    = 1'b1;
                    n_state  = S_OUT;
                end else begin
                    if (r_open) begin
                        n_d_valid[r_slot[D_IDX_W-1:0]] = 1'b1;
                    end
                    n_d_slot = DSLOT_W'(r_slot);
                    n_d_open = r_open;
                    n_d_rx   = r_rx_tot;
                    n_d_tx   = add_sum;
                    n_ring   = 1'b1;
                    n_state  = S_TAIL;
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= MIN_YEAR_RESET;
            r_ring     <= 1'b0;
            r_d_tail   <= '0;
            r_m_tail   <= '0;
            r_d_valid  <= '0;
            r_m_valid  <= '0;
        end else begin
            r_min_year <= n_min_year;
            r_ring     <= n_ring;
            r_d_tail   <= n_d_tail;
            r_m_tail   <= n_m_tail;
            r_d_valid  <= n_d_valid;
            r_m_valid  <= n_m_valid;
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_rx     <= n_rx;
        r_tx     <= n_tx;
        r_rd_idx <= n_rd_idx;
        r_slot   <= n_slot;
        r_open   <= n_open;
        r_rx_tot <= n_rx_tot;
        r_acc    <= n_acc;
        r_d_slot <= n_d_slot;
        r_d_open <= n_d_open;
        r_d_rx   <= n_d_rx;
        r_d_tx   <= n_d_tx;
        r_m_slot <= n_m_slot;
        r_m_open <= n_m_open;
        r_m_rx   <= n_m_rx;
        r_m_tx   <= n_m_tx;
    end

    // Bucket keys and sums of both rings.
    dkth_ram #(.WIDTH(KEY_W), .DEPTH(DAILY_DEPTH)) u_d_key (
        .i_clk   (i_clk),
        .i_we    (d_key_we),
        .i_waddr (r_slot[D_IDX_W-1:0]),
        .i_wdata (r_key),
        .i_raddr (key_raddr[D_IDX_W-1:0]),
        .o_rdata (d_key_rdata)
    );

    dkth_ram #(.WIDTH(2*CNT_W), .DEPTH(DAILY_DEPTH)) u_d_sum (
        .i_clk   (i_clk),
        .i_we    (d_sum_we),
        .i_waddr (r_slot[D_IDX_W-1:0]),
        .i_wdata (sum_wdata),
        .i_raddr (r_slot[D_IDX_W-1:0]),
        .o_rdata (d_sum_rdata)
    );

    dkth_ram #(.WIDTH(KEY_W), .DEPTH(MONTHLY_DEPTH)) u_m_key (
        .i_clk   (i_clk),
        .i_we    (m_key_we),
        .i_waddr (r_slot[M_IDX_W-1:0]),
        .i_wdata (cur_key),
        .i_raddr (key_raddr[M_IDX_W-1:0]),
        .o_rdata (m_key_rdata)
    );

    dkth_ram #(.WIDTH(2*CNT_W), .DEPTH(MONTHLY_DEPTH)) u_m_sum (
        .i_clk   (i_clk),
        .i_we    (m_sum_we),
        .i_waddr (r_slot[M_IDX_W-1:0]),
        .i_wdata (sum_wdata),
        .i_raddr (r_slot[M_IDX_W-1:0]),
        .o_rdata (m_sum_rdata)
    );

    // Result item.
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tuser  = r_acc;
    assign m_axis_tdata  = {{(OUT_W - OUT_USED_W){1'b0}},
                            r_m_tx, r_m_rx, r_m_open, r_m_slot,
                            r_d_tx, r_d_rx, r_d_open, r_d_slot};

`ifndef SYNTHESIS
    // Only one item is in work: no new item while a result waits.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result is pending");

    // A rejected sample gives an all-zero result.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("rejected sample with nonzero result");

    // A newly opened daily bucket is the new tail.
    a_d_open_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0] && r_d_open)
            |-> (DSLOT_W'(r_d_tail) == r_d_slot))
        else $error("daily bucket opened away from the tail");

    // A newly opened monthly bucket is the new tail.
    a_m_open_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0] && r_m_open)
            |-> (MSLOT_W'(r_m_tail) == r_m_slot))
        else $error("monthly bucket opened away from the tail");

    // The scan index stays inside the ring in work.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rd_idx <= ring_last))
        else $error("key scan left the ring");
`endif

endmodule
